[sv/mec_pkg.sv]
// shared types, constants and helpers for the mandelbrot escape counter
`timescale 1ns / 1ps

package mec_pkg;

    localparam int WORD_W      = 32;
    localparam int PROD_W      = 2 * WORD_W;
    localparam int PIX_W       = 16;
    localparam int STEP_W      = 31;
    localparam int ITER_W      = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int FRAC_BITS_D = 28;
    localparam int COUNT_BITS_D = 16;

    localparam logic signed [WORD_W-1:0] X_ORIGIN_RST = -32'sd536870912;
    localparam logic [STEP_W-1:0]        X_STEP_RST   = 31'd1048576;
    localparam logic signed [WORD_W-1:0] Y_ORIGIN_RST = -32'sd268435456;
    localparam logic [STEP_W-1:0]        Y_STEP_RST   = 31'd1048576;
    localparam logic [ITER_W-1:0]        MAX_ITER_RST = 16'd256;

    localparam logic signed [PROD_W-1:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [PROD_W-1:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        IDX_X_ORIGIN = 3'd0,
        IDX_X_STEP   = 3'd1,
        IDX_Y_ORIGIN = 3'd2,
        IDX_Y_STEP   = 3'd3,
        IDX_MAX_ITER = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] x_origin;
        logic [STEP_W-1:0]        x_step;
        logic signed [WORD_W-1:0] y_origin;
        logic [STEP_W-1:0]        y_step;
        logic [ITER_W-1:0]        max_iterations;
    } mec_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CRE,
        ST_CIM,
        ST_GXX,
        ST_GYY,
        ST_UPD,
        ST_MXX
    } state_t;

    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [PROD_W-1:0] v);
        logic signed [WORD_W-1:0] r;
        if (v > SAT_MAX)
        begin
            r = SAT_MAX[WORD_W-1:0];
        end
        else if (v < SAT_MIN)
        begin
            r = SAT_MIN[WORD_W-1:0];
        end
        else
        begin
            r = v[WORD_W-1:0];
        end
        return r;
    endfunction

endpackage

[sv/mandelbrot_escape_counter_unit.sv]
// top level: sequencer and datapath around one shared multiplier
// each iteration makes three passes through the single multiplier
// (x*x issued, then y*y, then x*y) and ends in one update/escape decision
// one item at a time; a new start is taken while done strobes
// reset: rst_n clears the sequencer and loads the default view and limit 256
`timescale 1ns / 1ps

module mandelbrot_escape_counter_unit
    import mec_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_D,
    parameter int COUNT_BITS = COUNT_BITS_D
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [PIX_W-1:0]     pixel_column,
    input  logic [PIX_W-1:0]     pixel_row,
    output logic                 done,
    output logic [ITER_W-1:0]    iteration_count,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data
);

    localparam int          LIM_W     = 33;
    localparam logic [LIM_W-1:0]  COUNT_MAX = (LIM_W'(1) << COUNT_BITS) - LIM_W'(1);
    localparam logic [PROD_W-1:0] FOUR      = PROD_W'(4) << FRAC_BITS;

    mec_cfg_t cfg;

    state_t state_reg, state_next;
    logic                     done_reg, done_next;
    logic [COUNT_BITS-1:0]    count_reg, count_next;
    logic [PIX_W-1:0]         row_reg, row_next;
    logic signed [WORD_W-1:0] c_re_reg, c_re_next;
    logic signed [WORD_W-1:0] c_im_reg, c_im_next;
    logic signed [WORD_W-1:0] x_reg, x_next;
    logic signed [WORD_W-1:0] y_reg, y_next;
    logic signed [PROD_W-1:0] xx_reg, xx_next;
    logic signed [PROD_W-1:0] yy_reg, yy_next;

    logic signed [WORD_W-1:0] op_a, op_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] prod_sh, two_xy;
    logic [PROD_W-1:0]        lensq;
    logic [LIM_W-1:0]         limit, count_ext;
    logic                     keep_going;

    mec_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mec_mult u_mult (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // limit clamped to what the counter can hold
    assign limit = (LIM_W'(cfg.max_iterations) > COUNT_MAX) ? COUNT_MAX
                                                             : LIM_W'(cfg.max_iterations);
    assign count_ext  = LIM_W'(count_reg);
    assign prod_sh    = prod >>> FRAC_BITS;
    assign two_xy     = prod >>> (FRAC_BITS - 1);
    assign lensq      = $unsigned(xx_reg) + $unsigned(yy_reg);
    assign keep_going = (count_ext < limit) && (lensq < FOUR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg  <= row_next;
        c_re_reg <= c_re_next;
        c_im_reg <= c_im_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        xx_reg   <= xx_next;
        yy_reg   <= yy_next;
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        row_next   = row_reg;
        c_re_next  = c_re_reg;
        c_im_next  = c_im_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        xx_next    = xx_reg;
        yy_next    = yy_reg;
        op_a       = x_reg;
        op_b       = x_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                op_a = WORD_W'(pixel_column);
                op_b = WORD_W'(cfg.x_step);
                if (start)
                begin
                    row_next   = pixel_row;
                    count_next = '0;
                    x_next     = '0;
                    y_next     = '0;
                    state_next = ST_CRE;
                end
            end
            ST_CRE:
            begin
                c_re_next  = sat_word(PROD_W'(cfg.x_origin) + prod);
                op_a       = WORD_W'(row_reg);
                op_b       = WORD_W'(cfg.y_step);
                state_next = ST_CIM;
            end
            ST_CIM:
            begin
                c_im_next  = sat_word(PROD_W'(cfg.y_origin) + prod);
                state_next = ST_GXX;
            end
            ST_MXX:
            begin
                state_next = ST_GXX;
            end
            ST_GXX:
            begin
                xx_next    = prod_sh;
                op_a       = y_reg;
                op_b       = y_reg;
                state_next = ST_GYY;
            end
            ST_GYY:
            begin
                yy_next    = prod_sh;
                op_a       = x_reg;
                op_b       = y_reg;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                // xx, yy of the current z double as its escape test
                if (keep_going)
                begin
                    x_next     = sat_word(xx_reg - yy_reg + PROD_W'(c_re_reg));
                    y_next     = sat_word(two_xy + PROD_W'(c_im_reg));
                    count_next = count_reg + 1'b1;
                    state_next = ST_MXX;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy            = (state_reg != ST_IDLE);
    assign done            = done_reg;
    assign iteration_count = count_ext[ITER_W-1:0];

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while sequencer busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start the sequencer");

    a_stay_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !start) |=> !busy)
        else $error("sequencer left idle without an item");

endmodule

[sv/mec_cfg_regs.sv]
// configuration register bank with its write decode
`timescale 1ns / 1ps

module mec_cfg_regs
    import mec_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    output mec_cfg_t             cfg
);

    mec_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_origin       <= X_ORIGIN_RST;
            cfg_reg.x_step         <= X_STEP_RST;
            cfg_reg.y_origin       <= Y_ORIGIN_RST;
            cfg_reg.y_step         <= Y_STEP_RST;
            cfg_reg.max_iterations <= MAX_ITER_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                IDX_X_ORIGIN: cfg_reg.x_origin       <= cfg_data;
                IDX_X_STEP:   cfg_reg.x_step         <= cfg_data[STEP_W-1:0];
                IDX_Y_ORIGIN: cfg_reg.y_origin       <= cfg_data;
                IDX_Y_STEP:   cfg_reg.y_step         <= cfg_data[STEP_W-1:0];
                IDX_MAX_ITER: cfg_reg.max_iterations <= cfg_data[ITER_W-1:0];
                default:      ;
            endcase
        end
    end

endmodule

[sv/mec_mult.sv]
// shared signed 32x32 multiplier with registered product
`timescale 1ns / 1ps

module mec_mult
    import mec_pkg::*;
(
    input  logic                     clk,
    input  logic signed [WORD_W-1:0] op_a,
    input  logic signed [WORD_W-1:0] op_b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

[tb/sv/mandelbrot_escape_counter_checker.sv]
// checker: predicts the escape count of every accepted pixel and compares each result
`timescale 1ns / 1ps

module mandelbrot_escape_counter_checker
    import mec_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_D,
    parameter int COUNT_BITS = COUNT_BITS_D
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic [PIX_W-1:0]     pixel_column,
    input  logic [PIX_W-1:0]     pixel_row,
    input  logic                 done,
    input  logic [ITER_W-1:0]    iteration_count,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    output int                   fail_count,
    output int                   pending
);

    localparam longint WORD_MAX    = 64'sh0000_0000_7FFF_FFFF;
    localparam longint WORD_MIN    = -64'sh0000_0000_8000_0000;
    localparam longint ESCAPE_MAG  = longint'(4) << FRAC_BITS;
    localparam longint LIMIT_CLAMP = (longint'(1) << COUNT_BITS) - 1;
    localparam int     MAX_PRINTS  = 50;

    typedef struct packed {
        logic [PIX_W-1:0]  col;
        logic [PIX_W-1:0]  row;
        logic [ITER_W-1:0] count;
    } pixel_result_t;

    mec_cfg_t      view;
    pixel_result_t expected_counts[$];
    pixel_result_t oldest;

    function automatic longint clamp_word(input longint v);
        longint r;
        if (v > WORD_MAX)
        begin
            r = WORD_MAX;
        end
        else if (v < WORD_MIN)
        begin
            r = WORD_MIN;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    // products are exact at 64 bits; >>> on a signed value is a floor divide
    function automatic logic [ITER_W-1:0] escape_count(input mec_cfg_t v,
                                                       input logic [PIX_W-1:0] col,
                                                       input logic [PIX_W-1:0] row);
        longint c_re;
        longint c_im;
        longint zr;
        longint zi;
        longint rr;
        longint ii;
        longint ri;
        longint mag;
        longint limit;
        longint n;
        c_re = clamp_word(longint'($signed(v.x_origin)) + longint'(col) * longint'(v.x_step));
        c_im = clamp_word(longint'($signed(v.y_origin)) + longint'(row) * longint'(v.y_step));
        limit = longint'(v.max_iterations);
        if (limit > LIMIT_CLAMP)
        begin
            limit = LIMIT_CLAMP;
        end
        zr  = 0;
        zi  = 0;
        mag = 0;
        n   = 0;
        while (n < limit && mag < ESCAPE_MAG)
        begin
            rr  = (zr * zr) >>> FRAC_BITS;
            ii  = (zi * zi) >>> FRAC_BITS;
            ri  = (zr * zi) >>> (FRAC_BITS - 1);
            zr  = clamp_word(rr - ii + c_re);
            zi  = clamp_word(ri + c_im);
            // magnitude is kept wide, no saturation
            mag = ((zr * zr) >>> FRAC_BITS) + ((zi * zi) >>> FRAC_BITS);
            n++;
        end
        return n[ITER_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input pixel_result_t ex,
                                   input logic [ITER_W-1:0] got);
        if (fail_count < MAX_PRINTS)
        begin
            $display("tb: mismatch (%s) pixel %0d,%0d count %0d expected %0d at %0t",
                     what, ex.col, ex.row, got, ex.count, $realtime);
        end
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view = '{X_ORIGIN_RST, X_STEP_RST, Y_ORIGIN_RST, Y_STEP_RST, MAX_ITER_RST};
            expected_counts.delete();
            pending = 0;
        end
        else
        begin
            // results first: a new item may be taken in the cycle done strobes
            if (done)
            begin
                if (expected_counts.size() == 0)
                begin
                    report_mismatch("unexpected result", '0, iteration_count);
                end
                else
                begin
                    oldest = expected_counts.pop_front();
                    if (iteration_count !== oldest.count)
                    begin
                        report_mismatch("iteration_count", oldest, iteration_count);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    IDX_X_ORIGIN: view.x_origin = cfg_data;
                    IDX_X_STEP:   view.x_step = cfg_data[STEP_W-1:0];
                    IDX_Y_ORIGIN: view.y_origin = cfg_data;
                    IDX_Y_STEP:   view.y_step = cfg_data[STEP_W-1:0];
                    IDX_MAX_ITER: view.max_iterations = cfg_data[ITER_W-1:0];
                    default:      ;
                endcase
            end
            if (start && !busy)
            begin
                expected_counts.push_back('{pixel_column, pixel_row,
                                            escape_count(view, pixel_column, pixel_row)});
            end
            pending = expected_counts.size();
        end
    end

endmodule

[tb/sv/tb_mandelbrot_escape_counter_unit.sv]
// testbench top: drives pixels and view settings into the escape counter, gives the verdict
`timescale 1ns / 1ps

module tb_mandelbrot_escape_counter_unit;
    import mec_pkg::*;

    localparam int CLK_HALF   = 10;
    localparam int RST_CYCLES = 10;
    localparam int TAIL_WAIT  = 50;
    localparam int TIMEOUT_NS = 200_000_000;

    // q4.28 view constants
    localparam logic [WORD_W-1:0] VIEW_LEFT   = -32'sd536870912;  // -2.0
    localparam logic [WORD_W-1:0] VIEW_BOTTOM = -32'sd335544320;  // -1.25
    localparam logic [WORD_W-1:0] VIEW_STEP   = 32'd2621440;      // 2.5 / 256
    localparam logic [WORD_W-1:0] SEAHORSE_RE = -32'sd201326592;  // -0.75
    localparam logic [WORD_W-1:0] SEAHORSE_IM = 32'sd26843546;    // 0.1
    localparam logic [WORD_W-1:0] WIDE_SPAN   = 32'd805306368;    // 3.0

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [PIX_W-1:0]     pixel_column;
    logic [PIX_W-1:0]     pixel_row;
    logic                 done;
    logic [ITER_W-1:0]    iteration_count;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_data;
    int                   fail_count;
    int                   pending;
    bit                   idling_on;

    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    mandelbrot_escape_counter_unit i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .pixel_column    (pixel_column),
        .pixel_row       (pixel_row),
        .done            (done),
        .iteration_count (iteration_count),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    mandelbrot_escape_counter_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .pixel_column    (pixel_column),
        .pixel_row       (pixel_row),
        .done            (done),
        .iteration_count (iteration_count),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    // all tasks are entered and left just after a falling edge
    task automatic send_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row);
        int gap;
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            start <= 1'b0;
            // idle cycles only show once the unit is free again
            while (busy)
                @(negedge clk);
            repeat (gap) @(negedge clk);
        end
        start        <= 1'b1;
        pixel_column <= col;
        pixel_row    <= row;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // leaves cfg_valid high so back-to-back writes need no second assignment
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic set_view(input logic [WORD_W-1:0] x_org, input logic [WORD_W-1:0] x_stp,
                            input logic [WORD_W-1:0] y_org, input logic [WORD_W-1:0] y_stp,
                            input logic [WORD_W-1:0] max_it);
        wait_idle();
        write_reg(IDX_X_ORIGIN, x_org);
        write_reg(IDX_X_STEP, x_stp);
        write_reg(IDX_Y_ORIGIN, y_org);
        write_reg(IDX_Y_STEP, y_stp);
        write_reg(IDX_MAX_ITER, max_it);
        cfg_valid <= 1'b0;
    endtask

    // mostly inside the visible window, sometimes anywhere
    function automatic logic [PIX_W-1:0] pick_coord(input int span);
        logic [PIX_W-1:0] c;
        if ($urandom_range(0, 3) != 0)
        begin
            c = PIX_W'($urandom_range(0, span - 1));
        end
        else
        begin
            c = PIX_W'($urandom);
        end
        return c;
    endfunction

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        pixel_column = '0;
        pixel_row    = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        idling_on    = 1'b1;
        repeat (RST_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset view: corners, c = 0 (runs to the limit), escape with |z|^2 exactly 4
        send_pixel('0, '0);
        send_pixel('1, '1);
        send_pixel(PIX_W'(512), PIX_W'(256));
        send_pixel('0, PIX_W'(256));
        send_pixel('1, '0);
        send_pixel('0, '1);

        // point out of range both ways, components overflow; masked upper data bits
        set_view(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0, 32'hABCD_0010);
        send_pixel('1, '1);
        send_pixel('0, '0);
        set_view(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd16);
        send_pixel('0, '0);
        send_pixel('1, '1);

        // zero limit, then writes to unused indexes must leave it alone
        set_view(VIEW_LEFT, VIEW_STEP, VIEW_BOTTOM, VIEW_STEP, 32'd0);
        send_pixel(PIX_W'(100), PIX_W'(128));
        wait_idle();
        for (int idx = IDX_MAX_ITER + 1; idx < (1 << CFG_IDX_W); idx++)
        begin
            write_reg(CFG_IDX_W'(idx), '1);
        end
        cfg_valid <= 1'b0;
        send_pixel(PIX_W'(100), PIX_W'(128));
        wait_idle();
        write_reg(IDX_MAX_ITER, 32'd1);
        cfg_valid <= 1'b0;
        send_pixel('0, '0);

        // full 16-bit limit: one quick escape, one point that never leaves
        set_view(X_ORIGIN_RST, 32'(X_STEP_RST), Y_ORIGIN_RST, 32'(Y_STEP_RST), 32'd65535);
        send_pixel('0, '0);
        send_pixel(PIX_W'(512), PIX_W'(256));

        // whole set at moderate depth
        set_view(VIEW_LEFT, VIEW_STEP, VIEW_BOTTOM, VIEW_STEP, 32'd64);
        repeat (250) send_pixel(pick_coord(256), pick_coord(256));

        // deep zoom on the boundary, long orbits
        set_view(SEAHORSE_RE + $urandom_range(0, 1 << 20), $urandom_range(1, 8192),
                 SEAHORSE_IM + $urandom_range(0, 1 << 20), $urandom_range(1, 8192), 32'd200);
        repeat (150) send_pixel(pick_coord(256), pick_coord(256));

        // single iteration, arbitrary register contents
        set_view($urandom, $urandom, $urandom, $urandom, ($urandom & 32'hFFFF_0000) | 32'd1);
        repeat (150) send_pixel(PIX_W'($urandom), PIX_W'($urandom));

        // random views: two within the set's neighborhood, two with raw data
        repeat (2)
        begin
            set_view($urandom_range(0, WIDE_SPAN) + VIEW_LEFT, $urandom_range(0, 1 << 22),
                     $urandom_range(0, WIDE_SPAN) + VIEW_BOTTOM, $urandom_range(0, 1 << 22),
                     $urandom_range(1, 48));
            repeat (50) send_pixel(pick_coord(1024), pick_coord(1024));
        end
        repeat (2)
        begin
            set_view($urandom, $urandom, $urandom, $urandom,
                     ($urandom & 32'hFFFF_0000) | $urandom_range(1, 32));
            repeat (50) send_pixel(PIX_W'($urandom), PIX_W'($urandom));
        end

        // back to back, no gaps
        idling_on = 1'b0;
        set_view(VIEW_LEFT, VIEW_STEP, VIEW_BOTTOM, VIEW_STEP, 32'd20);
        repeat (200) send_pixel(pick_coord(256), pick_coord(256));

        wait_idle();
        repeat (TAIL_WAIT) @(negedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

endmodule
